[sv/entity_id_allocator_with_signatures_unit_macros.svh]
// Assertion macros for the entity ID allocator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_UNIT_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define EIA_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define EIA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/eia_pkg.sv]
// Package for the entity ID allocator: sizes, codes, FSM state and
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package eia_pkg;

	localparam int ENTITY_COUNT = 1024;
	localparam int ID_W         = $clog2(ENTITY_COUNT);
	localparam int SIG_W        = 32;
	localparam int LIVE_W       = $clog2(ENTITY_COUNT + 1);

	typedef enum logic [1:0] {
		FN_CREATE  = 2'd0,
		FN_DESTROY = 2'd1,
		FN_GET     = 2'd2,
		FN_SET     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_NONE_LIVE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic commit;
	} eia_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} eia_sts_t;

endpackage

[sv/eia_if.sv]
// Request and response channel interfaces for the entity ID allocator.
// Depends on eia_pkg for field widths.
`timescale 1ns / 1ps

interface eia_req_if;
	import eia_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [ID_W-1:0]   entity_id;
	logic [SIG_W-1:0]  signature_in;

	modport source (output valid, func, entity_id, signature_in, input ready);
	modport sink   (input valid, func, entity_id, signature_in, output ready);
endinterface

interface eia_rsp_if;
	import eia_pkg::*;

	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   id_out;
	logic              id_valid;
	logic [SIG_W-1:0]  signature_out;
	logic [1:0]        status;
	logic [LIVE_W-1:0] live_count;

	modport source (output valid, id_out, id_valid, signature_out, status, live_count,
		input ready);
	modport sink   (input valid, id_out, id_valid, signature_out, status, live_count,
		output ready);
endinterface

[sv/eia_ctrl.sv]
// Controller FSM for the entity ID allocator: clearing pass, accept, commit.
// Depends on eia_pkg.
`timescale 1ns / 1ps

module eia_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  eia_pkg::eia_sts_t sts,
	output eia_pkg::eia_cmd_t cmd,
	output logic              req_ready,
	output eia_pkg::state_t   state
);
	import eia_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_EXEC: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign state = state_q;

endmodule

[sv/eia_dp.sv]
// Datapath for the entity ID allocator: free ring, signature and live-flag
// memories, ring pointers, live count and result register. Depends on eia_pkg, eia_if.
`timescale 1ns / 1ps

module eia_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  eia_pkg::eia_cmd_t        cmd,
	output eia_pkg::eia_sts_t        sts,
	input  logic [1:0]               func,
	input  logic [eia_pkg::ID_W-1:0] entity_id,
	input  logic [eia_pkg::SIG_W-1:0] signature_in,
	eia_rsp_if.source                rsp
);
	import eia_pkg::*;

	localparam logic [ID_W-1:0]   ID_LAST    = ID_W'(ENTITY_COUNT - 1);
	localparam logic [LIVE_W-1:0] LIVE_FULL  = LIVE_W'(ENTITY_COUNT);
	localparam logic [ID_W:0]     ID_LIMIT   = (ID_W + 1)'(ENTITY_COUNT);

	// Memories
	logic [ID_W-1:0]  ring_mem [ENTITY_COUNT];
	logic [SIG_W-1:0] sig_mem  [ENTITY_COUNT];
	logic             live_mem [ENTITY_COUNT];

	// Control state
	logic [ID_W-1:0]   clr_cnt_q;
	logic [ID_W-1:0]   head_q;
	logic [ID_W-1:0]   tail_q;
	logic              wrapped_q;
	logic [LIVE_W-1:0] live_q;
	logic              out_valid_q;

	// Captured item and read data
	logic [1:0]       func_q;
	logic [ID_W-1:0]  id_q;
	logic [SIG_W-1:0] sig_q;
	logic [ID_W-1:0]  ring_rd_q;
	logic [SIG_W-1:0] sig_rd_q;
	logic             live_rd_q;

	// Result register
	logic [ID_W-1:0]   res_id_q;
	logic              res_valid_q;
	logic [SIG_W-1:0]  res_sig_q;
	logic [1:0]        res_status_q;
	logic [LIVE_W-1:0] res_live_q;

	// Operation decode
	logic              in_range;
	logic              ring_hit;
	logic [ID_W-1:0]   new_id;
	logic              do_pop;
	logic              do_push;
	logic              do_set;
	logic [ID_W-1:0]   id_res;
	logic              valid_res;
	logic [SIG_W-1:0]  sig_res;
	status_t           status_res;
	logic [LIVE_W-1:0] live_nxt;

	// Memory write ports
	logic              sig_we;
	logic [ID_W-1:0]   sig_wa;
	logic [SIG_W-1:0]  sig_wd;
	logic              live_we;
	logic [ID_W-1:0]   live_wa;
	logic              live_wd;

	// Decode the captured item
	always_comb begin
		in_range   = {1'b0, id_q} < ID_LIMIT;
		// ring entries at or past the tail before its first wrap were never written
		ring_hit   = wrapped_q || (head_q < tail_q);
		new_id     = ring_hit ? ring_rd_q : head_q;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		do_set     = 1'b0;
		id_res     = id_q;
		valid_res  = 1'b0;
		sig_res    = '0;
		status_res = ST_OK;
		live_nxt   = live_q;
		case (func_q)
			FN_CREATE: begin
				if (live_q >= LIVE_FULL) begin
					status_res = ST_NO_FREE;
					id_res     = '0;
				end else begin
					do_pop    = 1'b1;
					id_res    = new_id;
					valid_res = 1'b1;
					live_nxt  = live_q + LIVE_W'(1);
				end
			end
			FN_DESTROY: begin
				if (live_q == '0) begin
					status_res = ST_NONE_LIVE;
				end else if (in_range) begin
					do_push  = 1'b1;
					live_nxt = live_q - LIVE_W'(1);
				end
			end
			FN_GET: begin
				if (in_range) begin
					sig_res   = sig_rd_q;
					valid_res = live_rd_q;
				end
			end
			FN_SET: begin
				if (in_range) begin
					do_set    = 1'b1;
					valid_res = live_rd_q;
				end
			end
			default: begin
				status_res = ST_OK;
			end
		endcase
	end

	// Select one write per memory
	always_comb begin
		sig_we  = 1'b0;
		sig_wa  = id_q;
		sig_wd  = '0;
		live_we = 1'b0;
		live_wa = id_q;
		live_wd = 1'b0;
		if (cmd.clr_wr) begin
			sig_we  = 1'b1;
			sig_wa  = clr_cnt_q;
			live_we = 1'b1;
			live_wa = clr_cnt_q;
		end else if (cmd.commit) begin
			if (do_pop) begin
				live_we = 1'b1;
				live_wa = new_id;
				live_wd = 1'b1;
			end
			if (do_push) begin
				sig_we  = 1'b1;
				live_we = 1'b1;
			end
			if (do_set) begin
				sig_we = 1'b1;
				sig_wd = sig_q;
			end
		end
	end

	// Access memories; read data registered on capture
	always_ff @(posedge clk) begin
		if (sig_we) sig_mem[sig_wa] <= sig_wd;
		if (live_we) live_mem[live_wa] <= live_wd;
		if (cmd.commit && do_push) ring_mem[tail_q] <= id_q;
		if (cmd.capture) begin
			ring_rd_q <= ring_mem[head_q];
			sig_rd_q  <= sig_mem[entity_id];
			live_rd_q <= live_mem[entity_id];
		end
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			id_q   <= entity_id;
			sig_q  <= signature_in;
		end
	end

	// Load the result
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_id_q     <= id_res;
			res_valid_q  <= valid_res;
			res_sig_q    <= sig_res;
			res_status_q <= status_res;
			res_live_q   <= live_nxt;
		end
	end

	// Advance pointers, live count, clear counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			wrapped_q   <= 1'b0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_cnt_q <= clr_cnt_q + ID_W'(1);
			if (cmd.commit) begin
				live_q <= live_nxt;
				if (do_pop) head_q <= (head_q == ID_LAST) ? '0 : head_q + ID_W'(1);
				if (do_push) begin
					tail_q <= (tail_q == ID_LAST) ? '0 : tail_q + ID_W'(1);
					if (tail_q == ID_LAST) wrapped_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clr_last = (clr_cnt_q == ID_LAST);
	assign sts.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid         = out_valid_q;
	assign rsp.id_out        = res_id_q;
	assign rsp.id_valid      = res_valid_q;
	assign rsp.signature_out = res_sig_q;
	assign rsp.status        = res_status_q;
	assign rsp.live_count    = res_live_q;

endmodule

[sv/entity_id_allocator_with_signatures_unit.sv]
// Entity ID allocator with a FIFO free list and a per-ID signature table.
// After reset the block runs a clearing pass over the signature and live-flag
// memories and accepts no item until it ends. Each operation then runs in an
// accept step, which reads the free ring, signature and live-flag memories, and
// a commit step, which writes them back and loads the result register. Because
// the memory reads are registered, commit is a step of its own. A result not yet
// taken holds commit; the next item is accepted once the result is loaded.
// Top level; depends on eia_pkg, eia_if, eia_ctrl, eia_dp and the macro header.
`timescale 1ns / 1ps
`include "entity_id_allocator_with_signatures_unit_macros.svh"

module entity_id_allocator_with_signatures_unit (
	input  logic      clk,
	input  logic      arst_n,
	eia_req_if.sink   req,
	eia_rsp_if.source rsp
);
	import eia_pkg::*;

	eia_cmd_t cmd;
	eia_sts_t sts;
	state_t   state;
	logic     ready;

	eia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.cmd       (cmd),
		.req_ready (ready),
		.state     (state)
	);

	eia_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (req.func),
		.entity_id    (req.entity_id),
		.signature_in (req.signature_in),
		.rsp          (rsp)
	);

	assign req.ready = ready;

	// Checks
	`EIA_ASSERT_IMPLIES(a_no_accept_in_clear, state == S_CLEAR, !req.ready, "item taken during clear")
	`EIA_ASSERT_NEXT(a_accept_to_exec, req.valid && req.ready, state == S_EXEC, "accept lost")
	`EIA_ASSERT_IMPLIES(a_no_free_full, rsp.valid && rsp.status == ST_NO_FREE, !rsp.id_valid && rsp.live_count == LIVE_W'(ENTITY_COUNT), "no-free status while not full")

endmodule
